@@ src/tssim_pkg.sv @@
// shared types, constants and weight lookup for the tiled ssim accumulator
`default_nettype none
package tssim_pkg;

  localparam int unsigned DefRadius     = 3;
  localparam int unsigned DefMaxWindows = 65536;

  localparam logic [15:0] WeightCenterRst = 16'd10624;
  localparam logic [15:0] WeightOff01Rst  = 16'd6443;
  localparam logic [15:0] WeightOff02Rst  = 16'd1438;
  localparam logic [15:0] WeightOff11Rst  = 16'd3908;
  localparam logic [15:0] WeightOff12Rst  = 16'd872;
  localparam logic [15:0] WeightOff22Rst  = 16'd195;
  localparam logic [31:0] StabC1Rst       = 32'd1665;
  localparam logic [31:0] StabC2Rst       = 32'd14982;

  localparam logic [2:0] RegWeightCenter = 3'd0;
  localparam logic [2:0] RegWeightOff01  = 3'd1;
  localparam logic [2:0] RegWeightOff02  = 3'd2;
  localparam logic [2:0] RegWeightOff11  = 3'd3;
  localparam logic [2:0] RegWeightOff12  = 3'd4;
  localparam logic [2:0] RegWeightOff22  = 3'd5;
  localparam logic [2:0] RegStabC1       = 3'd6;
  localparam logic [2:0] RegStabC2       = 3'd7;

  localparam int unsigned CfgIdxW = 4;

  // weight class 0..5 from absolute row/column offsets
  function automatic logic [2:0] weight_class(input logic [2:0] ay, input logic [2:0] ax);
    logic [2:0] lo;
    logic [2:0] hi;
    begin
      lo = (ay < ax) ? ay : ax;
      hi = (ay < ax) ? ax : ay;
      if (lo == 3'd0 && hi == 3'd0)      weight_class = 3'd0;
      else if (lo == 3'd0 && hi == 3'd1) weight_class = 3'd1;
      else if (lo == 3'd0)               weight_class = 3'd2;
      else if (lo == 3'd1 && hi == 3'd1) weight_class = 3'd3;
      else if (lo == 3'd1)               weight_class = 3'd4;
      else                               weight_class = 3'd5;
    end
  endfunction

  // datapath commands from the controller
  typedef struct packed {
    logic load;        // accept an item and accumulate its weighted sums
    logic clr_sums;    // clear sums and position
    logic means;       // latch mu values
    logic pass_step;   // second pass, one stored pixel
    logic pass_clr;    // clear variance accumulators
    logic lum;         // form luminance terms
    logic con;         // form contrast terms
    logic div_start;   // start a divider
    logic div_sel;     // 0 luminance, 1 contrast
    logic prod;        // ssim product
    logic commit;      // update totals and form output
    logic mean_start;  // start the mean divider
  } tssim_cmd_t;

  typedef struct packed {
    logic win_end;     // accepted item closes a window
    logic pass_done;   // last stored pixel processed
    logic div_busy;
    logic is_last;     // the closing item carried last_of_image
  } tssim_sts_t;

endpackage
`default_nettype wire

@@ src/tssim_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module tssim_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 48
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 busy,
  output logic [NumW-1:0]      quo
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_r, quo_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DenW:0]   trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r[DenW-1:0], quo_r[NumW-1]};
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CntW'(NumW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
endmodule
`default_nettype wire

@@ src/tssim_ctrl.sv @@
// controller state machine sequencing load, second pass, divisions and output
`default_nettype none
module tssim_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire tssim_pkg::tssim_sts_t sts,
  output tssim_pkg::tssim_cmd_t      cmd
);
  typedef enum logic [11:0] {
    S_LOAD  = 12'b000000000001,
    S_MEANS = 12'b000000000010,
    S_PASS  = 12'b000000000100,
    S_TERMS = 12'b000000001000,
    S_LDIV  = 12'b000000010000,
    S_LWAIT = 12'b000000100000,
    S_CDIV  = 12'b000001000000,
    S_CWAIT = 12'b000010000000,
    S_PROD  = 12'b000100000000,
    S_COMMIT= 12'b001000000000,
    S_MWAIT = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_stall  = (state_r != S_LOAD);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = acc;
        if (acc && sts.win_end) state_nxt = S_MEANS;
      end
      S_MEANS: begin
        cmd.means    = 1'b1;
        cmd.pass_clr = 1'b1;
        state_nxt    = S_PASS;
      end
      S_PASS: begin
        cmd.pass_step = 1'b1;
        if (sts.pass_done) state_nxt = S_TERMS;
      end
      S_TERMS: begin
        cmd.lum   = 1'b1;
        cmd.con   = 1'b1;
        state_nxt = S_LDIV;
      end
      S_LDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_LWAIT;
      end
      S_LWAIT: begin
        if (!sts.div_busy) state_nxt = S_CDIV;
      end
      S_CDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit     = 1'b1;
        cmd.mean_start = sts.is_last;
        state_nxt      = sts.is_last ? S_MWAIT : S_OUT;
      end
      S_MWAIT: begin
        if (!sts.div_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.clr_sums = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/tssim_dp.sv @@
// datapath: window buffer, weighted sums, second pass, ratios and totals
`default_nettype none
module tssim_dp #(
  parameter int unsigned WindowRadius = tssim_pkg::DefRadius,
  parameter int unsigned MaxWindows   = tssim_pkg::DefMaxWindows
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tssim_pkg::tssim_cmd_t cmd,
  output tssim_pkg::tssim_sts_t      sts,
  input  wire logic [15:0]           pixel_a,
  input  wire logic [15:0]           pixel_b,
  input  wire logic                  last_of_image,
  input  wire logic [15:0]           w0,
  input  wire logic [15:0]           w1,
  input  wire logic [15:0]           w2,
  input  wire logic [15:0]           w3,
  input  wire logic [15:0]           w4,
  input  wire logic [15:0]           w5,
  input  wire logic [31:0]           c1,
  input  wire logic [31:0]           c2,
  output logic [15:0]                window_number,
  output logic signed [17:0]         window_ssim,
  output logic signed [17:0]         mean_ssim,
  output logic                       is_final
);
  localparam int unsigned Side   = 2 * WindowRadius - 1;
  localparam int unsigned Pixels = Side * Side;
  localparam int unsigned PosW   = $clog2(Pixels);
  localparam int unsigned CrdW   = $clog2(Side);
  localparam int unsigned WdW    = $clog2(MaxWindows + 1);
  localparam logic [2:0]  Ctr    = 3'(WindowRadius - 1);

  // window buffer
  logic [15:0] store_a [Pixels];
  logic [15:0] store_b [Pixels];
  logic [15:0] rd_a_r, rd_b_r;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CrdW-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [39:0]     sum_a_r, sum_b_r;
  logic            last_r;

  // second pass pointer and registered read stage
  logic [PosW-1:0] rp_r;
  logic [CrdW-1:0] rrow_r, rcol_r;
  logic            rv_r;
  logic [15:0]     rw_r;

  logic [32:0] mu_a_r, mu_b_r;   // Q16.8, max 2^24
  logic signed [63:0] var_a_r, var_b_r, cov_r;

  logic [63:0] ln_r, ld_r, cd_r;
  logic signed [63:0] cn_r;
  logic [16:0] lr_r, crm_r;
  logic        crn_r;
  logic [17:0] ssim_r;

  logic signed [39:0] tot_r;
  logic [WdW-1:0]     wd_r;
  logic [15:0]        num_r;
  logic               fin_r;
  logic               tot_neg_r;

  // weight select
  function automatic logic [15:0] wsel(input logic [CrdW-1:0] r, input logic [CrdW-1:0] c,
      input logic [15:0] a0, input logic [15:0] a1, input logic [15:0] a2,
      input logic [15:0] a3, input logic [15:0] a4, input logic [15:0] a5);
    logic [2:0] ry, cx, ay, ax;
    logic [2:0] k;
    begin
      ry = 3'(r);
      cx = 3'(c);
      ay = (ry >= Ctr) ? ry - Ctr : Ctr - ry;
      ax = (cx >= Ctr) ? cx - Ctr : Ctr - cx;
      k  = tssim_pkg::weight_class(ay, ax);
      case (k)
        3'd0:    wsel = a0;
        3'd1:    wsel = a1;
        3'd2:    wsel = a2;
        3'd3:    wsel = a3;
        3'd4:    wsel = a4;
        default: wsel = a5;
      endcase
    end
  endfunction

  logic [15:0] wl;
  assign wl = wsel(row_r, col_r, w0, w1, w2, w3, w4, w5);

  // weighted pixel products, 16 x 16 bits
  logic [31:0] wpa, wpb;
  assign wpa = wl * pixel_a;
  assign wpb = wl * pixel_b;

  logic win_end;
  assign win_end = (pos_r == PosW'(Pixels - 1));

  always_comb begin
    pos_nxt = pos_r + 1'b1;
    row_nxt = row_r;
    col_nxt = col_r + 1'b1;
    if (col_r == CrdW'(Side - 1)) begin
      col_nxt = '0;
      row_nxt = row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_a[pos_r] <= pixel_a;
      store_b[pos_r] <= pixel_b;
    end
    rd_a_r <= store_a[rp_r];
    rd_b_r <= store_b[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_sums) begin
      pos_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
    end else if (cmd.load) begin
      sum_a_r <= sum_a_r + 40'(wpa);
      sum_b_r <= sum_b_r + 40'(wpb);
      if (!win_end) begin
        pos_r <= pos_nxt;
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      last_r <= last_of_image;
    end
  end

  // mean rounding with saturation
  function automatic logic [32:0] mean_q8(input logic [39:0] s);
    logic [32:0] t;
    begin
      t = (s > 40'hFFFFFFFF) ? 33'h0FFFFFFFF : {1'b0, s[31:0]};
      mean_q8 = (t + 33'd128) >> 8;
    end
  endfunction

  // second pass: read stage, then deviation/term stage
  logic [CrdW-1:0] rrow_nxt, rcol_nxt;
  always_comb begin
    rrow_nxt = rrow_r;
    rcol_nxt = rcol_r + 1'b1;
    if (rcol_r == CrdW'(Side - 1)) begin
      rcol_nxt = '0;
      rrow_nxt = rrow_r + 1'b1;
    end
  end

  logic signed [25:0] da, db;
  logic [24:0] ma, mb;
  logic [49:0] paa, pbb, pab;
  logic        nab;
  logic [24:0] ma_r, mb_r;
  logic        nab_r, pv_r;
  logic [15:0] pw_r;
  logic [49:0] paa_r, pbb_r, pab_r;
  logic        qv_r;
  logic        sv_r;
  logic [15:0] qw_r;
  logic        nab_q;

  assign da  = $signed({2'b0, rd_a_r, 8'b0}) - $signed({1'b0, mu_a_r[24:0]});
  assign db  = $signed({2'b0, rd_b_r, 8'b0}) - $signed({1'b0, mu_b_r[24:0]});
  assign ma  = da[25] ? 25'(-da) : da[24:0];
  assign mb  = db[25] ? 25'(-db) : db[24:0];
  assign nab = da[25] ^ db[25];

  // stage 1: magnitudes; stage 2: squared products; stage 3: weight and accumulate
  logic [65:0] taa, tbb, tab;
  always_comb begin
    taa = 66'(paa_r) * 66'(qw_r);
    tbb = 66'(pbb_r) * 66'(qw_r);
    tab = 66'(pab_r) * 66'(qw_r);
  end
  assign paa = 50'(ma_r) * 50'(ma_r);
  assign pbb = 50'(mb_r) * 50'(mb_r);
  assign pab = 50'(ma_r) * 50'(mb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      pv_r <= 1'b0;
      qv_r <= 1'b0;
      sv_r <= 1'b0;
      rp_r <= '0;
      rrow_r <= '0;
      rcol_r <= '0;
    end else begin
      if (cmd.pass_clr) begin
        rp_r   <= '0;
        rrow_r <= '0;
        rcol_r <= '0;
        rv_r   <= 1'b1;
      end else if (cmd.pass_step && rv_r) begin
        if (rp_r == PosW'(Pixels - 1)) begin
          rv_r <= 1'b0;
        end else begin
          rp_r   <= rp_r + 1'b1;
          rrow_r <= rrow_nxt;
          rcol_r <= rcol_nxt;
        end
      end
      pv_r <= cmd.pass_step && rv_r && !cmd.pass_clr;
      qv_r <= pv_r;
      sv_r <= qv_r;
    end
    rw_r  <= wsel(rrow_r, rcol_r, w0, w1, w2, w3, w4, w5);
    ma_r  <= ma;
    mb_r  <= mb;
    nab_r <= nab;
    pw_r  <= rw_r;
    paa_r <= paa;
    pbb_r <= pbb;
    pab_r <= pab;
    qw_r  <= pw_r;
    nab_q <= nab_r;
  end

  // rd_a_r holds the registered read of the buffer at rp_r; rw_r follows the same pointer
  logic pass_done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_done_r <= 1'b0;
    end else begin
      pass_done_r <= cmd.pass_step && !rv_r && !pv_r && qv_r;
    end
  end
  assign sts.pass_done = cmd.pass_step && !rv_r && !pv_r && !qv_r && pass_done_r;

  always_ff @(posedge clk) begin
    if (cmd.means) begin
      mu_a_r <= mean_q8(sum_a_r);
      mu_b_r <= mean_q8(sum_b_r);
    end
    if (cmd.pass_clr) begin
      var_a_r <= '0;
      var_b_r <= '0;
      cov_r   <= '0;
    end else if (sv_r) begin
      var_a_r <= var_a_r + $signed(64'(taa >> 24));
      var_b_r <= var_b_r + $signed(64'(tbb >> 24));
      cov_r   <= nab_q ? cov_r - $signed(64'(tab >> 24)) : cov_r + $signed(64'(tab >> 24));
    end
  end

  // luminance and contrast terms
  logic [65:0] mab, maa, mbb;
  assign mab = 66'(mu_a_r) * 66'(mu_b_r);
  assign maa = 66'(mu_a_r) * 66'(mu_a_r);
  assign mbb = 66'(mu_b_r) * 66'(mu_b_r);

  always_ff @(posedge clk) begin
    if (cmd.lum) begin
      ln_r <= 64'((mab << 1) >> 8) + 64'(c1);
      ld_r <= 64'((maa + mbb) >> 8) + 64'(c1);
    end
    if (cmd.con) begin
      cn_r <= (cov_r <<< 1) + $signed(64'(c2));
      cd_r <= 64'(var_a_r) + 64'(var_b_r) + 64'(c2);
    end
  end

  // totals including the window being committed
  logic               room;
  logic signed [39:0] tot_new;
  logic [WdW-1:0]     wd_new;
  assign room    = (wd_r < WdW'(MaxWindows));
  assign tot_new = room ? tot_r + 40'($signed(ssim_r)) : tot_r;
  assign wd_new  = room ? wd_r + 1'b1 : wd_r;

  // shared divider
  logic [63:0] dnum;
  logic [47:0] dden;
  logic        dbusy;
  logic [63:0] dquo;
  logic [63:0] cn_mag;
  logic [39:0] tot_mag;
  assign cn_mag  = cn_r[63] ? 64'(-cn_r) : 64'(cn_r);
  assign tot_mag = tot_new[39] ? 40'(-tot_new) : 40'(tot_new);

  always_comb begin
    if (cmd.mean_start) begin
      dnum = 64'(tot_mag);
      dden = 48'(wd_new);
    end else if (cmd.div_sel) begin
      dnum = {cn_mag[47:0], 16'b0};
      dden = cd_r[47:0];
    end else begin
      dnum = {ln_r[47:0], 16'b0};
      dden = ld_r[47:0];
    end
  end

  tssim_div #(.NumW(64), .DenW(48)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start || cmd.mean_start),
    .num   (dnum),
    .den   (dden),
    .busy  (dbusy),
    .quo   (dquo)
  );
  assign sts.div_busy = dbusy;

  logic [16:0] qsat;
  assign qsat = (dquo > 64'd65536) ? 17'd65536 : dquo[16:0];

  // latch quotients when the divider has drained
  logic ldiv_pend_r, cdiv_pend_r, mdiv_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldiv_pend_r <= 1'b0;
      cdiv_pend_r <= 1'b0;
      mdiv_pend_r <= 1'b0;
    end else begin
      if (cmd.div_start && !cmd.div_sel) ldiv_pend_r <= 1'b1;
      else if (ldiv_pend_r && !dbusy) ldiv_pend_r <= 1'b0;
      if (cmd.div_start && cmd.div_sel) cdiv_pend_r <= 1'b1;
      else if (cdiv_pend_r && !dbusy) cdiv_pend_r <= 1'b0;
      if (cmd.mean_start) mdiv_pend_r <= 1'b1;
      else if (mdiv_pend_r && !dbusy) mdiv_pend_r <= 1'b0;
    end
    if (ldiv_pend_r && !dbusy) lr_r <= (ld_r == '0) ? 17'd65536 : qsat;
    if (cdiv_pend_r && !dbusy) begin
      crm_r <= (cd_r == '0) ? 17'd65536 : qsat;
      crn_r <= (cd_r != '0) && cn_r[63];
    end
    if (mdiv_pend_r && !dbusy) begin
      mean_ssim <= tot_neg_r ? 18'(-dquo[17:0]) : dquo[17:0];
    end else if (cmd.commit) begin
      mean_ssim <= '0;
    end
  end

  logic [33:0] sp;
  assign sp = 34'(lr_r) * 34'(crm_r);
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      ssim_r <= crn_r ? 18'(-((sp + 34'd32768) >> 16)) : 18'((sp + 34'd32768) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
      wd_r  <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        tot_r <= '0;
        wd_r  <= '0;
      end else if (room) begin
        tot_r <= tot_new;
        wd_r  <= wd_new;
      end
    end
    if (cmd.commit) begin
      num_r       <= room ? 16'(wd_r) : 16'(MaxWindows - 1);
      fin_r       <= last_r;
      window_ssim <= ssim_r;
      tot_neg_r   <= tot_new[39];
    end
  end

  assign sts.win_end = win_end;
  assign sts.is_last = last_r;
  assign window_number = num_r;
  assign is_final      = fin_r;
endmodule
`default_nettype wire

@@ src/tiled_ssim_accumulator_unit.sv @@
// top level of the tiled ssim accumulator
// channels: in_ (pixel_a, pixel_b, last_of_image), out_ (window result), cfg_ (registers)
// an item is taken when in_valid is high and in_stall low; results leave likewise
// pixels load one per cycle while the unit is in its load phase
// after the last pixel of a window the unit stalls input for the second pass over the
// window pixels, two divisions, and, at the image end, one more division for the mean
// the result register holds while out_stall is high; input stays stalled meanwhile
// synchronous reset loads default weights and stabilizers and clears all counters
// the window buffer itself is not cleared; every entry is written before it is read
`default_nettype none
module tiled_ssim_accumulator_unit #(
  parameter int unsigned WindowRadius = tssim_pkg::DefRadius,
  parameter int unsigned MaxWindows   = tssim_pkg::DefMaxWindows
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [15:0]         in_pixel_a,
  input  wire logic [15:0]         in_pixel_b,
  input  wire logic                in_last_of_image,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [15:0]              out_window_number,
  output logic signed [17:0]       out_window_ssim,
  output logic signed [17:0]       out_mean_ssim,
  output logic                     out_is_final,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [tssim_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]         cfg_data
);
  logic [15:0] w0_r, w1_r, w2_r, w3_r, w4_r, w5_r;
  logic [31:0] c1_r, c2_r;
  logic        wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // register file; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r <= tssim_pkg::WeightCenterRst;
      w1_r <= tssim_pkg::WeightOff01Rst;
      w2_r <= tssim_pkg::WeightOff02Rst;
      w3_r <= tssim_pkg::WeightOff11Rst;
      w4_r <= tssim_pkg::WeightOff12Rst;
      w5_r <= tssim_pkg::WeightOff22Rst;
      c1_r <= tssim_pkg::StabC1Rst;
      c2_r <= tssim_pkg::StabC2Rst;
    end else if (wr && !cfg_index[3]) begin
      unique case (cfg_index[2:0])
        tssim_pkg::RegWeightCenter: w0_r <= cfg_data[15:0];
        tssim_pkg::RegWeightOff01:  w1_r <= cfg_data[15:0];
        tssim_pkg::RegWeightOff02:  w2_r <= cfg_data[15:0];
        tssim_pkg::RegWeightOff11:  w3_r <= cfg_data[15:0];
        tssim_pkg::RegWeightOff12:  w4_r <= cfg_data[15:0];
        tssim_pkg::RegWeightOff22:  w5_r <= cfg_data[15:0];
        tssim_pkg::RegStabC1:       c1_r <= cfg_data;
        tssim_pkg::RegStabC2:       c2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tssim_pkg::tssim_cmd_t cmd;
  tssim_pkg::tssim_sts_t sts;

  tssim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tssim_dp #(.WindowRadius(WindowRadius), .MaxWindows(MaxWindows)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .pixel_a       (in_pixel_a),
    .pixel_b       (in_pixel_b),
    .last_of_image (in_last_of_image),
    .w0 (w0_r), .w1 (w1_r), .w2 (w2_r), .w3 (w3_r), .w4 (w4_r), .w5 (w5_r),
    .c1 (c1_r), .c2 (c2_r),
    .window_number (out_window_number),
    .window_ssim   (out_window_ssim),
    .mean_ssim     (out_mean_ssim),
    .is_final      (out_is_final)
  );
endmodule
`default_nettype wire
